// ===== src/ugl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the UTF-8 glyph layout block.
// No dependencies; every other file but ugl_ram takes names from here by scope.
package ugl_pkg;

	localparam int GLYPH_SLOTS = 256;
	localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
	localparam int CNT_W       = 9;
	localparam int CODE_W      = 16;
	localparam int WID_W       = 5;
	localparam int RAM_W       = CODE_W + WID_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// input opcodes
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TEXT  = 2'd2;

	// command kinds between front and back
	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_LOOKUP = 2'd2;

	localparam logic [15:0] CODE_QMARK = 16'h003F;
	localparam logic signed [15:0] PEN_MAX = 16'sh7FFF;

	typedef struct packed {
		logic [1:0]         kind;
		logic [SLOT_W-1:0]  slot;
		logic [CODE_W-1:0]  code;
		logic [WID_W-1:0]   width;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [31:0]        color;
	} cmd_t;

	typedef struct packed {
		logic [7:0]         glyph_index;
		logic [7:0]         tex_u;
		logic [7:0]         tex_v;
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic [31:0]        sprite_color;
	} res_t;

endpackage

// ===== src/ugl_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ugl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/ugl_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the decode front and the search back.
// Depends on ugl_pkg (cmd_t, queue depth).
module ugl_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  ugl_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output ugl_pkg::cmd_t rd_cmd,
	output logic          empty
);

	ugl_pkg::cmd_t                 slots_q [ugl_pkg::QUEUE_DEPTH];
	logic [ugl_pkg::QPTR_W-1:0]    wptr_q;
	logic [ugl_pkg::QPTR_W-1:0]    rptr_q;
	logic [ugl_pkg::QPTR_W:0]      count_q;
	logic                          do_wr;
	logic                          do_rd;

	assign full   = (count_q == (ugl_pkg::QPTR_W+1)'(ugl_pkg::QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/ugl_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input transactions, decodes UTF-8 and classifies them
// into load, start and lookup commands. Depends on ugl_pkg.
module ugl_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [1:0]          opcode,
	input  logic [7:0]          text_byte,
	input  logic [7:0]          entry_slot,
	input  logic [15:0]         entry_code,
	input  logic [4:0]          entry_width,
	input  logic signed [15:0]  start_x,
	input  logic signed [15:0]  start_y,
	input  logic [31:0]         text_color,
	input  logic                q_full,
	output logic                cmd_push,
	output ugl_pkg::cmd_t       cmd
);

	logic [15:0] partial_q;
	logic [1:0]  left_q;
	logic [15:0] partial_d;
	logic [1:0]  left_d;
	logic        accept;
	logic        emit;
	logic [15:0] code;
	logic [15:0] shifted;

	assign accept  = push && !q_full;
	assign shifted = {partial_q[9:0], text_byte[5:0]};

	always_comb begin
		partial_d = partial_q;
		left_d    = left_q;
		emit      = 1'b0;
		code      = '0;
		case (opcode)
			ugl_pkg::OP_LOAD: begin
				emit = ({1'b0, entry_slot} < 9'(ugl_pkg::GLYPH_SLOTS));
			end
			ugl_pkg::OP_START: begin
				emit      = 1'b1;
				partial_d = '0;
				left_d    = '0;
			end
			ugl_pkg::OP_TEXT: begin
				if (left_q != 2'd0) begin
					partial_d = shifted;
					left_d    = left_q - 2'd1;
					emit      = (left_q == 2'd1);
					code      = shifted;
				end else if (text_byte < 8'h80) begin
					emit = 1'b1;
					code = {8'h00, text_byte};
				end else if (text_byte < 8'hE0) begin
					partial_d = {11'd0, text_byte[4:0]};
					left_d    = 2'd1;
				end else if (text_byte < 8'hF0) begin
					partial_d = {12'd0, text_byte[3:0]};
					left_d    = 2'd2;
				end else begin
					emit = 1'b1;
					code = ugl_pkg::CODE_QMARK;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.slot  = entry_slot[ugl_pkg::SLOT_W-1:0];
		cmd.code  = (opcode == ugl_pkg::OP_LOAD) ? entry_code : code;
		cmd.width = entry_width;
		cmd.x     = start_x;
		cmd.y     = start_y;
		cmd.color = text_color;
		case (opcode)
			ugl_pkg::OP_LOAD:  cmd.kind = ugl_pkg::CMD_LOAD;
			ugl_pkg::OP_START: cmd.kind = ugl_pkg::CMD_START;
			default:           cmd.kind = ugl_pkg::CMD_LOOKUP;
		endcase
	end

	assign cmd_push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			left_q    <= '0;
		end else if (accept) begin
			partial_q <= partial_d;
			left_q    <= left_d;
		end
	end

endmodule

// ===== src/ugl_back.sv =====
`timescale 1ns / 1ps
// Back end: executes commands in order. Holds the glyph table RAM, runs the
// binary search, keeps the pen and color, and owns the result register.
// Depends on ugl_pkg and ugl_ram.
module ugl_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ugl_pkg::CNT_W-1:0] glyph_count,
	input  ugl_pkg::cmd_t             cmd,
	input  logic                      cmd_empty,
	output logic                      cmd_pop,
	input  logic                      pop,
	output logic                      res_valid,
	output ugl_pkg::res_t             res
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PROBE = 2'd1;
	localparam logic [1:0] ST_CMP   = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]                      state_q;
	logic [ugl_pkg::CNT_W-1:0]       low_q;
	logic [ugl_pkg::CNT_W-1:0]       hi_q;
	logic [ugl_pkg::SLOT_W-1:0]      mid_q;
	logic [ugl_pkg::CODE_W-1:0]      code_q;
	logic [ugl_pkg::WID_W-1:0]       width_q;
	logic signed [15:0]              pen_x_q;
	logic signed [15:0]              pen_y_q;
	logic [31:0]                     color_q;
	logic                            out_valid_q;
	ugl_pkg::res_t                   out_q;

	logic [ugl_pkg::CNT_W-1:0]       n_eff;
	logic [ugl_pkg::CNT_W:0]         mid_sum;
	logic [ugl_pkg::SLOT_W-1:0]      mid;
	logic [ugl_pkg::RAM_W-1:0]       rdata;
	logic [ugl_pkg::CODE_W-1:0]      rd_code;
	logic                            ram_we;
	logic                            emit_fire;
	logic [7:0]                      idx8;
	logic signed [17:0]              pen_sum;

	assign n_eff   = (glyph_count > ugl_pkg::CNT_W'(ugl_pkg::GLYPH_SLOTS))
		? ugl_pkg::CNT_W'(ugl_pkg::GLYPH_SLOTS) : glyph_count;
	assign mid_sum = {1'b0, low_q} + {1'b0, hi_q} - 1'b1;
	assign mid     = ugl_pkg::SLOT_W'(mid_sum >> 1);
	assign rd_code = rdata[ugl_pkg::RAM_W-1:ugl_pkg::WID_W];

	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign ram_we    = cmd_pop && (cmd.kind == ugl_pkg::CMD_LOAD);
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || pop);

	ugl_ram #(
		.WIDTH(ugl_pkg::RAM_W),
		.DEPTH(ugl_pkg::GLYPH_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cmd.slot),
		.wdata ({cmd.code, cmd.width}),
		.raddr (mid),
		.rdata (rdata)
	);

	assign idx8    = 8'(mid_q);
	assign pen_sum = {{2{pen_x_q[15]}}, pen_x_q} + 18'({8'd0, width_q} + 13'd1) * 18'sd16;

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			out_q.glyph_index  <= idx8;
			out_q.tex_u        <= {idx8[3:0], 4'h0};
			out_q.tex_v        <= {idx8[7:4], 4'h0};
			out_q.screen_x     <= pen_x_q;
			out_q.screen_y     <= pen_y_q;
			out_q.sprite_color <= color_q;
		end
		if (cmd_pop && (cmd.kind == ugl_pkg::CMD_LOOKUP)) begin
			code_q <= cmd.code;
		end
		if (state_q == ST_PROBE) begin
			mid_q <= mid;
		end
		if (state_q == ST_CMP) begin
			width_q <= rdata[ugl_pkg::WID_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			low_q       <= '0;
			hi_q        <= '0;
			pen_x_q     <= '0;
			pen_y_q     <= '0;
			color_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.kind == ugl_pkg::CMD_START) begin
							pen_x_q <= cmd.x;
							pen_y_q <= cmd.y;
							color_q <= cmd.color;
						end else if (cmd.kind == ugl_pkg::CMD_LOOKUP) begin
							low_q   <= '0;
							hi_q    <= n_eff;
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					// empty range ends the search with a miss
					state_q <= (low_q < hi_q) ? ST_CMP : ST_IDLE;
				end
				ST_CMP: begin
					if (rd_code == code_q) begin
						state_q <= ST_EMIT;
					end else begin
						if (rd_code < code_q) begin
							low_q <= ugl_pkg::CNT_W'(mid_q) + 1'b1;
						end else begin
							hi_q <= ugl_pkg::CNT_W'(mid_q);
						end
						state_q <= ST_PROBE;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						pen_x_q <= (pen_sum > 18'(ugl_pkg::PEN_MAX))
							? ugl_pkg::PEN_MAX : pen_sum[15:0];
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

// ===== src/utf8_glyph_layout_core.sv =====
`timescale 1ns / 1ps
// Top level of the UTF-8 glyph layout block: APB register, front decoder,
// command queue and search back end. Depends on ugl_pkg and the src/ ugl_ modules.
//
//  channel   handshake             payload
//  -------   -------------------   ------------------------------------------
//  input     push / full           opcode, text_byte, entry_*, start_*, color
//  result    pop / empty           glyph_index, tex_u, tex_v, screen_*, color
//  config    psel/penable/pwrite   paddr, pwdata, prdata (glyph_count at 0)
//
// The front takes one input transaction per cycle while the four-entry
// command queue has room. The back takes a command only when idle; a load
// or start command is done as it is dequeued. A lookup is dequeued and then
// runs up to nine probes of the table RAM over 256 slots, each a PROBE state
// (address) then a CMP state (registered data and compare). A hit goes on to
// EMIT; a miss ends in PROBE on the empty range.
// The emit waits while the result register is full and not popped; a stalled
// back end fills the queue and then raises full.
// Reset clears decode state, pen, color, glyph_count and all handshakes; the
// glyph table is not cleared and holds garbage until loaded.
module utf8_glyph_layout_core (
	input  logic                clk,
	input  logic                arst_n,
	// input queue side
	input  logic                push,
	output logic                full,
	input  logic [1:0]          opcode,
	input  logic [7:0]          text_byte,
	input  logic [7:0]          entry_slot,
	input  logic [15:0]         entry_code,
	input  logic [4:0]          entry_width,
	input  logic signed [15:0]  start_x,
	input  logic signed [15:0]  start_y,
	input  logic [31:0]         text_color,
	// result register side
	output logic                empty,
	input  logic                pop,
	output logic [7:0]          glyph_index,
	output logic [7:0]          tex_u,
	output logic [7:0]          tex_v,
	output logic signed [15:0]  screen_x,
	output logic signed [15:0]  screen_y,
	output logic [31:0]         sprite_color,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [ugl_pkg::CNT_W-1:0] glyph_count_q;
	logic                      q_full;
	logic                      q_empty;
	logic                      q_push;
	logic                      q_pop;
	ugl_pkg::cmd_t             front_cmd;
	ugl_pkg::cmd_t             back_cmd;
	logic                      res_valid;
	ugl_pkg::res_t             res;

	// register file: glyph_count is the only register, at byte address zero
	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? 32'(glyph_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= '0;
		end else if (psel && penable && pwrite && pready && (paddr == 2'd0)) begin
			glyph_count_q <= pwdata[ugl_pkg::CNT_W-1:0];
		end
	end

	ugl_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.opcode      (opcode),
		.text_byte   (text_byte),
		.entry_slot  (entry_slot),
		.entry_code  (entry_code),
		.entry_width (entry_width),
		.start_x     (start_x),
		.start_y     (start_y),
		.text_color  (text_color),
		.q_full      (q_full),
		.cmd_push    (q_push),
		.cmd         (front_cmd)
	);

	ugl_cmd_fifo u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_cmd (front_cmd),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (back_cmd),
		.empty  (q_empty)
	);

	ugl_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.glyph_count (glyph_count_q),
		.cmd         (back_cmd),
		.cmd_empty   (q_empty),
		.cmd_pop     (q_pop),
		.pop         (pop),
		.res_valid   (res_valid),
		.res         (res)
	);

	// hold off new transactions while the command queue is full
	assign full  = q_full;
	assign empty = !res_valid;

	assign glyph_index  = res.glyph_index;
	assign tex_u        = res.tex_u;
	assign tex_v        = res.tex_v;
	assign screen_x     = res.screen_x;
	assign screen_y     = res.screen_y;
	assign sprite_color = res.sprite_color;

endmodule

// ===== verif/ugl_sprite_checker.sv =====
`timescale 1ns / 1ps
// Sprite checker for the UTF-8 glyph layout core: watches the input, result and
// register channels, predicts every sprite and compares it field by field.
// Depends on ugl_pkg for opcodes, widths and the result struct.
module ugl_sprite_checker #(
	parameter logic [1:0] COUNT_ADDR = 2'd0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [1:0]          opcode,
	input  logic [7:0]          text_byte,
	input  logic [7:0]          entry_slot,
	input  logic [15:0]         entry_code,
	input  logic [4:0]          entry_width,
	input  logic signed [15:0]  start_x,
	input  logic signed [15:0]  start_y,
	input  logic [31:0]         text_color,
	input  logic                empty,
	input  logic                pop,
	input  logic [7:0]          glyph_index,
	input  logic [7:0]          tex_u,
	input  logic [7:0]          tex_v,
	input  logic signed [15:0]  screen_x,
	input  logic signed [15:0]  screen_y,
	input  logic [31:0]         sprite_color,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [1:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  mismatches,
	output int                  sprites_owed
);

	import ugl_pkg::*;

	localparam int PRINT_CAP = 100;

	logic [CODE_W-1:0]  lut_code [GLYPH_SLOTS];
	logic [WID_W-1:0]   lut_width [GLYPH_SLOTS];
	logic [CODE_W-1:0]  utf_accum;
	logic [1:0]         utf_need;
	logic signed [15:0] cursor_x;
	logic signed [15:0] cursor_y;
	logic [31:0]        ink;
	logic [CNT_W-1:0]   search_len;
	res_t               sprites_due [$];

	initial begin
		mismatches = 0;
		sprites_owed = 0;
	end

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_CAP) begin
			$display("%0t ugl_sprite_checker: %s got %0h, expected %0h", $time, what, got, want);
		end
		mismatches++;
	endtask

	// binary search over the live part of the glyph table; -1 on a miss
	function automatic int search_slot(input logic [CODE_W-1:0] cp);
		int n;
		int lo;
		int hi;
		int mid;
		n = (search_len > GLYPH_SLOTS) ? GLYPH_SLOTS : int'(search_len);
		lo = 0;
		hi = n - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (lut_code[mid] == cp) return mid;
			if (lut_code[mid] < cp) lo = mid + 1;
			else hi = mid - 1;
		end
		return -1;
	endfunction

	task automatic place_glyph(input logic [CODE_W-1:0] cp);
		int slot;
		int nx;
		logic [7:0] idx;
		res_t s;
		slot = search_slot(cp);
		if (slot < 0) return;
		idx = slot[7:0];
		s.glyph_index  = idx;
		s.tex_u        = {idx[3:0], 4'b0000};
		s.tex_v        = {idx[7:4], 4'b0000};
		s.screen_x     = cursor_x;
		s.screen_y     = cursor_y;
		s.sprite_color = ink;
		sprites_due.push_back(s);
		// advance by width plus one pixel, clamp at the top of the range
		nx = int'(cursor_x) + (int'(lut_width[slot]) + 1) * 16;
		cursor_x = (nx > 32767) ? PEN_MAX : nx[15:0];
	endtask

	task automatic layout_step();
		case (opcode)
			OP_LOAD: begin
				lut_code[entry_slot] = entry_code;
				lut_width[entry_slot] = entry_width;
			end
			OP_START: begin
				cursor_x = start_x;
				cursor_y = start_y;
				ink = text_color;
				utf_accum = '0;
				utf_need = '0;
			end
			OP_TEXT: begin
				if (utf_need != 0) begin
					utf_accum = {utf_accum[9:0], text_byte[5:0]};
					utf_need = utf_need - 2'd1;
					if (utf_need == 0) place_glyph(utf_accum);
				end else if (text_byte < 8'h80) begin
					place_glyph({8'h00, text_byte});
				end else if (text_byte < 8'hE0) begin
					utf_accum = {11'b0, text_byte[4:0]};
					utf_need = 2'd1;
				end else if (text_byte < 8'hF0) begin
					utf_accum = {12'b0, text_byte[3:0]};
					utf_need = 2'd2;
				end else begin
					place_glyph(CODE_QMARK);
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_sprite();
		res_t want;
		if (sprites_due.size() == 0) begin
			flag_mismatch("sprite with none owed, glyph_index", glyph_index, '0);
			return;
		end
		want = sprites_due.pop_front();
		if (glyph_index !== want.glyph_index)
			flag_mismatch("glyph_index", glyph_index, want.glyph_index);
		if (tex_u !== want.tex_u) flag_mismatch("tex_u", tex_u, want.tex_u);
		if (tex_v !== want.tex_v) flag_mismatch("tex_v", tex_v, want.tex_v);
		if (screen_x !== want.screen_x)
			flag_mismatch("screen_x", {16'h0, screen_x}, {16'h0, want.screen_x});
		if (screen_y !== want.screen_y)
			flag_mismatch("screen_y", {16'h0, screen_y}, {16'h0, want.screen_y});
		if (sprite_color !== want.sprite_color)
			flag_mismatch("sprite_color", sprite_color, want.sprite_color);
	endtask

	// results first: nothing accepted at this edge can come out at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf_accum = '0;
			utf_need = '0;
			cursor_x = '0;
			cursor_y = '0;
			ink = '0;
			search_len = '0;
			sprites_due.delete();
			sprites_owed <= 0;
		end else begin
			if (pop && !empty) check_sprite();
			if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
				search_len = pwdata[CNT_W-1:0];
			if (push && !full) layout_step();
			sprites_owed <= sprites_due.size();
		end
	end

endmodule

// ===== verif/utf8_glyph_layout_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top of the UTF-8 glyph layout core: clock, reset, stimulus and verdict.
// Depends on ugl_pkg, the core and ugl_sprite_checker, which does all the checking.
module utf8_glyph_layout_core_tb;

	import ugl_pkg::*;

	localparam logic [1:0] OP_NONE          = 2'd3;
	localparam logic [1:0] GLYPH_COUNT_ADDR = 2'd0;
	localparam int SETTLE_CYCLES = 200;
	localparam int QUIET_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int PHASES        = 10;

	typedef struct {
		logic [1:0]         op;
		logic [7:0]         tbyte;
		logic [7:0]         slot;
		logic [15:0]        code;
		logic [4:0]         wid;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [31:0]        col;
	} text_cmd_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [1:0]         opcode = OP_NONE;
	logic [7:0]         text_byte = '0;
	logic [7:0]         entry_slot = '0;
	logic [15:0]        entry_code = '0;
	logic [4:0]         entry_width = '0;
	logic signed [15:0] start_x = '0;
	logic signed [15:0] start_y = '0;
	logic [31:0]        text_color = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [7:0]         glyph_index;
	logic [7:0]         tex_u;
	logic [7:0]         tex_v;
	logic signed [15:0] screen_x;
	logic signed [15:0] screen_y;
	logic [31:0]        sprite_color;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [1:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	int mismatches;
	int sprites_owed;

	// stimulus-side copy of the glyph table, used only to aim text at known codes
	logic [15:0] atlas_code [GLYPH_SLOTS];
	logic [4:0]  atlas_width [GLYPH_SLOTS];
	int          live_count = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	int          sink_mode = 0;
	int          sink_left = 0;
	int          sink_tick = 0;

	utf8_glyph_layout_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.text_byte    (text_byte),
		.entry_slot   (entry_slot),
		.entry_code   (entry_code),
		.entry_width  (entry_width),
		.start_x      (start_x),
		.start_y      (start_y),
		.text_color   (text_color),
		.empty        (empty),
		.pop          (pop),
		.glyph_index  (glyph_index),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.sprite_color (sprite_color),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	ugl_sprite_checker #(.COUNT_ADDR(GLYPH_COUNT_ADDR)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.text_byte    (text_byte),
		.entry_slot   (entry_slot),
		.entry_code   (entry_code),
		.entry_width  (entry_width),
		.start_x      (start_x),
		.start_y      (start_y),
		.text_color   (text_color),
		.empty        (empty),
		.pop          (pop),
		.glyph_index  (glyph_index),
		.tex_u        (tex_u),
		.tex_v        (tex_v),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.sprite_color (sprite_color),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.mismatches   (mismatches),
		.sprites_owed (sprites_owed)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result side: hold one stall style for a random stretch, then switch.
	// Styles: always ready, coin flip, mostly stalled, and a fixed 2-of-7 beat.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			sink_mode <= 0;
			sink_left <= 0;
			sink_tick <= 0;
		end else begin
			sink_tick <= sink_tick + 1;
			if (sink_left == 0) begin
				sink_mode <= $urandom_range(0, 3);
				sink_left <= $urandom_range(32, 300);
			end else begin
				sink_left <= sink_left - 1;
			end
			case (sink_mode)
				0: pop <= 1'b1;
				1: pop <= 1'($urandom_range(0, 1));
				2: pop <= ($urandom_range(0, 5) == 0);
				default: pop <= ((sink_tick % 7) < 2);
			endcase
		end
	end

	// Watchdog: any transaction on any channel resets the quiet count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("utf8_glyph_layout_core_tb: done, errors");
				$finish;
			end
		end
	end

	// Fill every field with noise; callers then set what the opcode uses.
	function automatic text_cmd_t noise_cmd(input logic [1:0] op);
		text_cmd_t c;
		c.op = op;
		c.tbyte = 8'($urandom);
		c.slot = 8'($urandom);
		c.code = 16'($urandom);
		c.wid = 5'($urandom);
		c.sx = 16'($urandom);
		c.sy = 16'($urandom);
		c.col = $urandom;
		return c;
	endfunction

	// Send one input transaction. The sender runs in bursts; at the end of a
	// burst drop push for a random gap, or carry straight on about a third of
	// the time so that long unbroken stretches also occur.
	task automatic issue(input text_cmd_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		opcode <= c.op;
		text_byte <= c.tbyte;
		entry_slot <= c.slot;
		entry_code <= c.code;
		entry_width <= c.wid;
		start_x <= c.sx;
		start_y <= c.sy;
		text_color <= c.col;
		do @(posedge clk); while (full);
		if (c.op == OP_LOAD) begin
			atlas_code[c.slot] = c.code;
			atlas_width[c.slot] = c.wid;
		end
		items_sent++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		text_cmd_t c;
		c = noise_cmd(OP_TEXT);
		c.tbyte = b;
		issue(c);
	endtask

	task automatic begin_string(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic [31:0] col);
		text_cmd_t c;
		c = noise_cmd(OP_START);
		c.sx = x;
		c.sy = y;
		c.col = col;
		issue(c);
	endtask

	task automatic load_slot(input logic [7:0] s, input logic [15:0] cp, input logic [4:0] w);
		text_cmd_t c;
		c = noise_cmd(OP_LOAD);
		c.slot = s;
		c.code = cp;
		c.wid = w;
		issue(c);
	endtask

	// Continuation bytes are not checked by the block: now and then give them
	// a random tag instead of 10.
	function automatic logic [7:0] cont_byte(input logic [5:0] bits);
		logic [1:0] tag;
		tag = 2'b10;
		if ($urandom_range(0, 7) == 0) tag = 2'($urandom_range(0, 3));
		return {tag, bits};
	endfunction

	// Encode a code point as one, two or three UTF-8 bytes.
	task automatic put_code(input logic [15:0] cp);
		if (cp < 16'h0080) begin
			put_byte(cp[7:0]);
		end else if (cp < 16'h0800) begin
			put_byte({3'b110, cp[10:6]});
			put_byte(cont_byte(cp[5:0]));
		end else begin
			put_byte({4'b1110, cp[15:12]});
			put_byte(cont_byte(cp[11:6]));
			put_byte(cont_byte(cp[5:0]));
		end
	endtask

	// Start a string; a third of them start near the right edge so that the
	// pen runs into its clamp within a few glyphs.
	task automatic random_string();
		logic signed [15:0] x;
		x = 16'($urandom);
		if ($urandom_range(0, 2) == 0) x = 16'($urandom_range(16'h7000, 16'h7FFF));
		begin_string(x, 16'($urandom), $urandom);
	endtask

	// Stop sending, wait until every predicted sprite has been popped, then
	// let any lookups that will miss work their way out of the block.
	task automatic drain();
		push <= 1'b0;
		do @(posedge clk); while (sprites_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write glyph_count with the block idle; junk in the unused upper bits.
	task automatic set_glyph_count(input int v);
		logic [31:0] junk;
		drain();
		junk = $urandom;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= GLYPH_COUNT_ADDR;
		pwdata <= (junk & ~32'h1FF) | (v & 32'h1FF);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		live_count = v & 32'h1FF;
	endtask

	// Mostly well-formed text aimed at codes in the live part of the table,
	// mixed with misses, raw byte noise, torn sequences, table rewrites and
	// the unused opcode.
	task automatic random_traffic(input int goal);
		int stop;
		int r;
		int s;
		int lo_c;
		int hi_c;
		int n_live;
		logic [15:0] cp;
		stop = items_sent + goal;
		n_live = (live_count > GLYPH_SLOTS) ? GLYPH_SLOTS : live_count;
		while (items_sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				random_string();
			end else if (r < 58) begin
				if (n_live > 0) put_code(atlas_code[$urandom_range(0, n_live - 1)]);
				else put_code(16'($urandom));
			end else if (r < 66) begin
				// random code point, usually a miss; bias toward short encodings
				cp = 16'($urandom);
				case ($urandom_range(0, 2))
					0: cp = cp & 16'h007F;
					1: cp = cp & 16'h07FF;
					default: ;
				endcase
				put_code(cp);
			end else if (r < 76) begin
				put_byte(8'($urandom));
			end else if (r < 80) begin
				// open a sequence and cut it off with a new string
				put_byte(8'($urandom_range(8'hC0, 8'hEF)));
				if ($urandom_range(0, 1)) put_byte(cont_byte(6'($urandom)));
				random_string();
			end else if (r < 84) begin
				issue(noise_cmd(OP_NONE));
			end else if (r < 96) begin
				// rewrite a slot and keep the table sorted where there is room
				s = $urandom_range(0, GLYPH_SLOTS - 1);
				lo_c = (s == 0) ? 0 : int'(atlas_code[s - 1]) + 1;
				hi_c = (s == GLYPH_SLOTS - 1) ? 65535 : int'(atlas_code[s + 1]) - 1;
				cp = atlas_code[s];
				if (lo_c <= hi_c) cp = 16'($urandom_range(lo_c, hi_c));
				load_slot(s[7:0], cp, 5'($urandom));
			end else begin
				// rare unsorted write: the search must still follow its probes
				load_slot(8'($urandom), 16'($urandom), 5'($urandom));
			end
		end
	endtask

	initial begin
		int s;
		int c;
		int sweep [PHASES];
		sweep = '{256, 1, 2, 0, 511, 300, 255, 17, 128, 256};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset: nothing may come out
		begin_string(16'sh0100, 16'sh0200, 32'h11223344);
		put_byte(8'h41);
		put_byte(8'hF0);

		// fill the whole table once, sorted: ASCII in the low half, a rising
		// walk up to 0xFFFF in the high half; widths at both extremes included
		c = 128;
		for (s = 0; s < GLYPH_SLOTS; s++) begin
			if (s < 128) begin
				atlas_code[s] = 16'(s);
			end else if (s < GLYPH_SLOTS - 1) begin
				c = c + $urandom_range(1, 500);
				atlas_code[s] = 16'(c);
			end else begin
				atlas_code[s] = 16'hFFFF;
			end
			atlas_width[s] = 5'($urandom);
			if (s == 0) atlas_width[s] = 5'd0;
			if (s == 8'h41) atlas_width[s] = 5'd31;
			load_slot(s[7:0], atlas_code[s], atlas_width[s]);
		end

		set_glyph_count(GLYPH_SLOTS);

		// directed: extremes of pen and color, every decode path
		begin_string(16'sh8000, 16'sh7FFF, 32'hFFFFFFFF);
		put_byte(8'h00);
		put_byte(8'h7F);
		put_byte(8'h3F);
		put_byte(8'hF0);
		put_byte(8'hFF);
		put_code(atlas_code[128]);
		put_code(16'hFFFF);
		// stray continuation taken as a two-byte lead: 0x80 0x81 gives code 1
		put_byte(8'h80);
		put_byte(8'h81);
		// open a three-byte sequence, then drop it with a new string near the clamp
		put_byte(8'hE2);
		begin_string(16'sh7F00, 16'sh8000, 32'h00000000);
		put_byte(8'h41);
		put_byte(8'h41);
		put_byte(8'h41);
		issue(noise_cmd(OP_NONE));
		// overlong two-byte form of 'A'
		put_byte(8'hC1);
		put_byte(8'h81);
		// two-byte code below the first high-half entry: a miss
		put_code(16'h0080);
		load_slot(8'd5, atlas_code[5], 5'd31);
		put_byte(8'h05);

		// sweep glyph_count through small, empty, full and oversize settings
		for (s = 0; s < PHASES; s++) begin
			c = sweep[s];
			if (s == PHASES - 1) c = $urandom_range(3, 255);
			set_glyph_count(c);
			random_traffic(RANDOM_ITEMS / PHASES);
		end

		drain();
		if (mismatches == 0 && sprites_owed == 0) begin
			$display("utf8_glyph_layout_core_tb: done, clean");
		end else begin
			$display("utf8_glyph_layout_core_tb: done, errors");
		end
		$finish;
	end

endmodule

// ===== utf8_glyph_layout_core.f =====
src/ugl_pkg.sv
src/ugl_ram.sv
src/ugl_cmd_fifo.sv
src/ugl_front.sv
src/ugl_back.sv
src/utf8_glyph_layout_core.sv
verif/ugl_sprite_checker.sv
verif/utf8_glyph_layout_core_tb.sv
